// ===== sv/ttpg_pkg.sv =====
// Shared constants, types and the arctangent step table for the tunnel pixel generator.
// Used by the division and rotation cells, the top level and the scoreboard; depends on nothing.
package ttpg_pkg;

    localparam int NUM_W      = 32;
    localparam int DEN_W      = 20;
    localparam int CORD_W     = 33;
    localparam int ANG_ITERS  = 16;
    localparam int SQRT_STEPS = 16;
    localparam int LANE_A     = 32;
    localparam int LANE_B     = 16;
    localparam int LANE_C     = 8;
    localparam int NUM_STAGES = 1 + 1 + LANE_A + 1 + 1 + LANE_B + 1 + LANE_C;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [17:0] ANG_MUL     = 18'd160000;
    // Reciprocal of 3927 scaled by 2^32, rounded up; exact for dividends below 2^20.
    localparam logic [20:0] ANG_RECIP   = 21'd1093702;

    localparam logic [15:0] RST_SCALE  = 16'd4096;
    localparam logic [9:0]  RST_XDIV   = 10'd100;
    localparam logic [9:0]  RST_YDIV   = 10'd200;
    localparam logic [8:0]  RST_PERIOD = 9'd37;
    localparam logic [8:0]  RST_CX     = 9'd160;
    localparam logic [7:0]  RST_CY     = 8'd120;

    typedef enum logic [2:0] {
        CFG_SCALE  = 3'd0,
        CFG_XDIV   = 3'd1,
        CFG_YDIV   = 3'd2,
        CFG_PERIOD = 3'd3,
        CFG_CX     = 3'd4,
        CFG_CY     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic dx_neg;
        logic dy_neg;
        logic dx_zero;
        logic dy_zero;
    } t_quad;

    typedef struct packed {
        logic [7:0] qx;
        logic [7:0] qy;
        logic       neg;
        logic       d0;
    } t_side;

    function automatic logic [29:0] atan_step(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd843314857;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043837;
            5'd3:  r = 30'd133525159;
            5'd4:  r = 30'd67021687;
            5'd5:  r = 30'd33543516;
            5'd6:  r = 30'd16775851;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194283;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048576;
            5'd11: r = 30'd524288;
            5'd12: r = 30'd262144;
            5'd13: r = 30'd131072;
            5'd14: r = 30'd65536;
            5'd15: r = 30'd32768;
            5'd16: r = 30'd16384;
            5'd17: r = 30'd8192;
            5'd18: r = 30'd4096;
            5'd19: r = 30'd2048;
            5'd20: r = 30'd1024;
            5'd21: r = 30'd512;
            5'd22: r = 30'd256;
            5'd23: r = 30'd128;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/ttpg_div_cell.sv =====
// One registered restoring division step: shifts in one numerator bit, yields one quotient bit.
// Depends on ttpg_pkg for the operand widths.
module ttpg_div_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ttpg_pkg::DEN_W-1:0] i_rem,
    input  logic [ttpg_pkg::NUM_W-1:0] i_num,
    input  logic [ttpg_pkg::DEN_W-1:0] i_den,
    output logic [ttpg_pkg::DEN_W-1:0] o_rem,
    output logic [ttpg_pkg::NUM_W-1:0] o_num,
    output logic [ttpg_pkg::DEN_W-1:0] o_den
);
    logic [ttpg_pkg::DEN_W-1:0] r_rem, n_rem;
    logic [ttpg_pkg::NUM_W-1:0] r_num, n_num;
    logic [ttpg_pkg::DEN_W-1:0] r_den;
    logic [ttpg_pkg::DEN_W:0]   trial;
    logic [ttpg_pkg::DEN_W:0]   diff;
    logic                       ge;

    always_comb begin
        trial = {i_rem, i_num[ttpg_pkg::NUM_W-1]};
        diff  = trial - {1'b0, i_den};
        ge    = trial >= {1'b0, i_den};
        n_rem = ge ? diff[ttpg_pkg::DEN_W-1:0] : trial[ttpg_pkg::DEN_W-1:0];
        n_num = {i_num[ttpg_pkg::NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_den <= i_den;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_den = r_den;
endmodule

// ===== sv/ttpg_cordic_cell.sv =====
// One registered vectoring rotation step of the angle chain.
// Depends on ttpg_pkg for the word width and the arctangent table.
module ttpg_cordic_cell (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [4:0]                          i_step,
    input  logic signed [ttpg_pkg::CORD_W-1:0] i_x,
    input  logic signed [ttpg_pkg::CORD_W-1:0] i_y,
    input  logic signed [ttpg_pkg::CORD_W-1:0] i_z,
    output logic signed [ttpg_pkg::CORD_W-1:0] o_x,
    output logic signed [ttpg_pkg::CORD_W-1:0] o_y,
    output logic signed [ttpg_pkg::CORD_W-1:0] o_z
);
    logic signed [ttpg_pkg::CORD_W-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic signed [ttpg_pkg::CORD_W-1:0] xs, ys, ang;

    always_comb begin
        xs  = i_x >>> i_step;
        ys  = i_y >>> i_step;
        ang = $signed({3'b000, ttpg_pkg::atan_step(i_step)});
        if (!i_y[ttpg_pkg::CORD_W-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ang;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

// ===== sv/ttpg_sqrt_cell.sv =====
// One registered digit step of the integer square root, two radicand bits per cell.
// Depends on nothing beyond its ports.
module ttpg_sqrt_cell (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [3:0]  i_step,
    input  logic [31:0] i_v,
    input  logic [31:0] i_root,
    output logic [31:0] o_v,
    output logic [31:0] o_root
);
    logic [31:0] r_v, r_root, n_v, n_root, bitv, trial;

    always_comb begin
        bitv  = 32'd1 << (5'd30 - {i_step, 1'b0});
        trial = i_root + bitv;
        if (i_v >= trial) begin
            n_v    = i_v - trial;
            n_root = (i_root >> 1) + bitv;
        end else begin
            n_v    = i_v;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= n_v;
            r_root <= n_root;
        end
    end

    assign o_v    = r_v;
    assign o_root = r_root;
endmodule

// ===== sv/tunnel_texture_pixel_generator.sv =====
// Top level of the tunnel pixel generator: configuration, front end, the cell chains and output.
// Depends on ttpg_pkg, ttpg_div_cell, ttpg_cordic_cell and ttpg_sqrt_cell.
// The block takes one pixel beat per clock while o_stall is low and returns one color index
// beat per pixel, in order, through the output register. The pipeline runs through
// the 32-cell division chains for the depth and frame shifts, the 16-cell square root chain
// that carries the scaled angle beside it, and the 8-cell chain that reduces by the texture
// period. A two-deep output (register plus skid) keeps input flowing while a result waits;
// configuration must only be written while no pixel is in flight.
module tunnel_texture_pixel_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [8:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    input  logic [15:0] i_frame_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_color_index,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    localparam int NA = ttpg_pkg::LANE_A;
    localparam int NB = ttpg_pkg::LANE_B;
    localparam int NC = ttpg_pkg::LANE_C;
    localparam int NI = ttpg_pkg::ANG_ITERS;
    localparam int NS = ttpg_pkg::SQRT_STEPS;
    localparam int DW = ttpg_pkg::DEN_W;
    localparam int QW = ttpg_pkg::NUM_W;
    localparam int CW = ttpg_pkg::CORD_W;

    logic [15:0] r_scale;
    logic [9:0]  r_xdiv, r_ydiv;
    logic [8:0]  r_period, r_cx;
    logic [7:0]  r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= ttpg_pkg::RST_SCALE;
            r_xdiv   <= ttpg_pkg::RST_XDIV;
            r_ydiv   <= ttpg_pkg::RST_YDIV;
            r_period <= ttpg_pkg::RST_PERIOD;
            r_cx     <= ttpg_pkg::RST_CX;
            r_cy     <= ttpg_pkg::RST_CY;
        end else if (i_cfg_we) begin
            unique case (ttpg_pkg::t_cfg_idx'(i_cfg_idx))
                ttpg_pkg::CFG_SCALE:  r_scale  <= i_cfg_data;
                ttpg_pkg::CFG_XDIV:   r_xdiv   <= i_cfg_data[9:0];
                ttpg_pkg::CFG_YDIV:   r_ydiv   <= i_cfg_data[9:0];
                ttpg_pkg::CFG_PERIOD: r_period <= i_cfg_data[8:0];
                ttpg_pkg::CFG_CX:     r_cx     <= i_cfg_data[8:0];
                ttpg_pkg::CFG_CY:     r_cy     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic [9:0] xdiv_eff, ydiv_eff;
    logic [8:0] per_eff;
    assign xdiv_eff = (r_xdiv == 10'd0) ? 10'd1 : r_xdiv;
    assign ydiv_eff = (r_ydiv == 10'd0) ? 10'd1 : r_ydiv;
    assign per_eff  = (r_period == 9'd0) ? 9'd256 : r_period;

    logic r_ov, n_ov, r_sv, n_sv;
    logic [7:0] r_od, n_od, r_sd, n_sd;
    logic en, acc;
    logic [ttpg_pkg::NUM_STAGES-1:0] r_vld;

    assign en      = !r_sv;
    assign o_stall = r_sv;
    assign acc     = i_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[ttpg_pkg::NUM_STAGES-2:0], acc};
        end
    end

    // Entry stage: offsets to the center.
    logic signed [9:0] r_e_dx, r_e_dy;
    logic [15:0]       r_e_frame;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_dx    <= $signed({1'b0, i_pixel_x}) - $signed({1'b0, r_cx});
            r_e_dy    <= $signed({2'b00, i_pixel_y}) - $signed({2'b00, r_cy});
            r_e_frame <= i_frame_number;
        end
    end

    // Square stage.
    logic [19:0]       r_m_d2;
    logic [31:0]       r_m_s2;
    logic [23:0]       r_m_fnum;
    logic [8:0]        r_m_ax, r_m_ay;
    ttpg_pkg::t_quad   r_m_quad;
    logic [9:0]        absx, absy;
    logic signed [19:0] sqx, sqy;
    always_comb begin
        absx = r_e_dx[9] ? 10'(-r_e_dx) : r_e_dx;
        absy = r_e_dy[9] ? 10'(-r_e_dy) : r_e_dy;
        sqx  = r_e_dx * r_e_dx;
        sqy  = r_e_dy * r_e_dy;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_d2           <= 20'(sqx) + 20'(sqy);
            r_m_s2           <= r_scale * r_scale;
            r_m_fnum         <= {r_e_frame, 8'd0};
            r_m_ax           <= absx[8:0];
            r_m_ay           <= absy[8:0];
            r_m_quad.dx_neg  <= r_e_dx[9];
            r_m_quad.dy_neg  <= r_e_dy[9];
            r_m_quad.dx_zero <= (r_e_dx == 10'sd0);
            r_m_quad.dy_zero <= (r_e_dy == 10'sd0);
        end
    end

    // First chain: three dividers, the rotation cells and side data.
    logic [DW-1:0] a_dep_rem[NA], a_dep_den[NA], a_xs_rem[NA], a_xs_den[NA];
    logic [DW-1:0] a_ys_rem[NA], a_ys_den[NA];
    logic [QW-1:0] a_dep_num[NA], a_xs_num[NA], a_ys_num[NA];
    logic signed [CW-1:0] c_x[NI], c_y[NI], c_z[NI];
    logic signed [CW-1:0] a_z[NA];
    ttpg_pkg::t_quad a_quad[NA];

    genvar k;
    generate
        for (k = 0; k < NA; k++) begin : g_a
            if (k == 0) begin : g_first
                ttpg_div_cell u_dep (.i_clk(i_clk), .i_en(en), .i_rem('0), .i_num(r_m_s2),
                    .i_den(r_m_d2), .o_rem(a_dep_rem[k]), .o_num(a_dep_num[k]),
                    .o_den(a_dep_den[k]));
                ttpg_div_cell u_xs (.i_clk(i_clk), .i_en(en), .i_rem('0),
                    .i_num({8'd0, r_m_fnum}), .i_den({10'd0, xdiv_eff}),
                    .o_rem(a_xs_rem[k]), .o_num(a_xs_num[k]), .o_den(a_xs_den[k]));
                ttpg_div_cell u_ys (.i_clk(i_clk), .i_en(en), .i_rem('0),
                    .i_num({8'd0, r_m_fnum}), .i_den({10'd0, ydiv_eff}),
                    .o_rem(a_ys_rem[k]), .o_num(a_ys_num[k]), .o_den(a_ys_den[k]));
                ttpg_cordic_cell u_cor (.i_clk(i_clk), .i_en(en), .i_step(5'(k)),
                    .i_x($signed({4'd0, r_m_ax, 20'd0})), .i_y($signed({4'd0, r_m_ay, 20'd0})),
                    .i_z('0), .o_x(c_x[k]), .o_y(c_y[k]), .o_z(c_z[k]));
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        a_quad[k] <= r_m_quad;
                    end
                end
            end else begin : g_next
                ttpg_div_cell u_dep (.i_clk(i_clk), .i_en(en), .i_rem(a_dep_rem[k-1]),
                    .i_num(a_dep_num[k-1]), .i_den(a_dep_den[k-1]), .o_rem(a_dep_rem[k]),
                    .o_num(a_dep_num[k]), .o_den(a_dep_den[k]));
                ttpg_div_cell u_xs (.i_clk(i_clk), .i_en(en), .i_rem(a_xs_rem[k-1]),
                    .i_num(a_xs_num[k-1]), .i_den(a_xs_den[k-1]), .o_rem(a_xs_rem[k]),
                    .o_num(a_xs_num[k]), .o_den(a_xs_den[k]));
                ttpg_div_cell u_ys (.i_clk(i_clk), .i_en(en), .i_rem(a_ys_rem[k-1]),
                    .i_num(a_ys_num[k-1]), .i_den(a_ys_den[k-1]), .o_rem(a_ys_rem[k]),
                    .o_num(a_ys_num[k]), .o_den(a_ys_den[k]));
                if (k < NI) begin : g_cor
                    ttpg_cordic_cell u_cor (.i_clk(i_clk), .i_en(en), .i_step(5'(k)),
                        .i_x(c_x[k-1]), .i_y(c_y[k-1]), .i_z(c_z[k-1]),
                        .o_x(c_x[k]), .o_y(c_y[k]), .o_z(c_z[k]));
                end
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        a_quad[k] <= a_quad[k-1];
                    end
                end
            end
            if (k < NI) begin : g_zc
                assign a_z[k] = c_z[k];
            end else begin : g_zr
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        a_z[k] <= a_z[k-1];
                    end
                end
            end
        end
    endgenerate

    // Angle assembly stage.
    logic [31:0] r_p_q, r_p_mag, zc, mag;
    logic [7:0]  r_p_qx, r_p_qy;
    logic        r_p_neg, r_p_d0, neg;
    ttpg_pkg::t_quad qd;
    always_comb begin
        qd = a_quad[NA-1];
        if (a_z[NA-1] < 0) begin
            zc = 32'd0;
        end else if (a_z[NA-1] > $signed({1'b0, ttpg_pkg::HALF_PI_Q30})) begin
            zc = ttpg_pkg::HALF_PI_Q30;
        end else begin
            zc = a_z[NA-1][31:0];
        end
        if (qd.dy_zero) begin
            mag = qd.dx_neg ? ttpg_pkg::PI_Q30 : 32'd0;
            neg = 1'b0;
        end else if (qd.dx_zero) begin
            mag = ttpg_pkg::HALF_PI_Q30;
            neg = qd.dy_neg;
        end else begin
            mag = qd.dx_neg ? ttpg_pkg::PI_Q30 - zc : zc;
            neg = qd.dy_neg;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_q   <= a_dep_num[NA-1];
            r_p_qx  <= a_xs_num[NA-1][7:0];
            r_p_qy  <= a_ys_num[NA-1][7:0];
            r_p_mag <= mag;
            r_p_neg <= neg;
            r_p_d0  <= qd.dx_zero && qd.dy_zero;
        end
    end

    // Angle scaling multiply stage.
    logic [19:0]     r_x_w;
    logic [31:0]     r_x_q;
    ttpg_pkg::t_side r_x_side;
    logic [49:0]     prod;
    assign prod = r_p_mag * ttpg_pkg::ANG_MUL;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x_w        <= prod[49:30];
            r_x_q        <= r_p_q;
            r_x_side.qx  <= r_p_qx;
            r_x_side.qy  <= r_p_qy;
            r_x_side.neg <= r_p_neg;
            r_x_side.d0  <= r_p_d0;
        end
    end

    // Second chain: square root cells, with the angle quotient carried beside them.
    logic [40:0]   aprod;
    logic [7:0]    b_t[NB];
    logic [31:0]   s_v[NS], s_root[NS];
    logic [31:0]   b_root[NB];
    ttpg_pkg::t_side b_side[NB];

    assign aprod = r_x_w * ttpg_pkg::ANG_RECIP;

    generate
        for (k = 0; k < NB; k++) begin : g_b
            if (k == 0) begin : g_first
                ttpg_sqrt_cell u_sq (.i_clk(i_clk), .i_en(en), .i_step(4'(k)), .i_v(r_x_q),
                    .i_root(32'd0), .o_v(s_v[k]), .o_root(s_root[k]));
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        b_t[k]    <= aprod[39:32];
                        b_side[k] <= r_x_side;
                    end
                end
            end else begin : g_next
                if (k < NS) begin : g_sq
                    ttpg_sqrt_cell u_sq (.i_clk(i_clk), .i_en(en), .i_step(4'(k)),
                        .i_v(s_v[k-1]), .i_root(s_root[k-1]), .o_v(s_v[k]),
                        .o_root(s_root[k]));
                end
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        b_t[k]    <= b_t[k-1];
                        b_side[k] <= b_side[k-1];
                    end
                end
            end
            if (k < NS) begin : g_rc
                assign b_root[k] = s_root[k];
            end else begin : g_rr
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        b_root[k] <= b_root[k-1];
                    end
                end
            end
        end
    endgenerate

    // Texture combine stage.
    logic [7:0] r_f_x, t8, ang8, dep8;
    ttpg_pkg::t_side bs;
    always_comb begin
        bs   = b_side[NB-1];
        t8   = b_t[NB-1];
        ang8 = bs.neg ? 8'(8'd0 - t8) : t8;
        dep8 = bs.d0 ? 8'd0 : b_root[NB-1][7:0];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_x <= 8'(dep8 + bs.qx) ^ 8'(ang8 + bs.qy);
        end
    end

    // Third chain: reduction by the texture period.
    logic [DW-1:0] m_rem[NC], m_den[NC];
    logic [QW-1:0] m_num[NC];
    generate
        for (k = 0; k < NC; k++) begin : g_c
            if (k == 0) begin : g_first
                ttpg_div_cell u_mod (.i_clk(i_clk), .i_en(en), .i_rem('0),
                    .i_num({r_f_x, 24'd0}), .i_den({11'd0, per_eff}), .o_rem(m_rem[k]),
                    .o_num(m_num[k]), .o_den(m_den[k]));
            end else begin : g_next
                ttpg_div_cell u_mod (.i_clk(i_clk), .i_en(en), .i_rem(m_rem[k-1]),
                    .i_num(m_num[k-1]), .i_den(m_den[k-1]), .o_rem(m_rem[k]),
                    .o_num(m_num[k]), .o_den(m_den[k]));
            end
        end
    endgenerate

    logic       tail_v;
    logic [7:0] tail_d;
    assign tail_v = r_vld[ttpg_pkg::NUM_STAGES-1];
    assign tail_d = m_rem[NC-1][7:0];

    always_comb begin
        n_ov = r_ov;
        n_sv = r_sv;
        n_od = r_od;
        n_sd = r_sd;
        if (r_sv) begin
            if (!i_stall) begin
                n_ov = 1'b1;
                n_od = r_sd;
                n_sv = 1'b0;
            end
        end else if (r_ov && i_stall) begin
            if (tail_v) begin
                n_sv = 1'b1;
                n_sd = tail_d;
            end
        end else begin
            n_ov = tail_v;
            n_od = tail_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od <= n_od;
        r_sd <= n_sd;
    end

    assign o_valid       = r_ov;
    assign o_color_index = r_od;
    // The sqrt leftovers and the unused quotient bits of the period chain are not needed
    // past their chains.
endmodule

// ===== sv/ttpg_checker.sv =====
// Port-level checks for the tunnel pixel generator, bound to the top level.
// Depends only on the top level's ports.
module ttpg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [8:0]  i_pixel_x,
    input logic [7:0]  i_pixel_y,
    input logic [15:0] i_frame_number,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_color_index,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_idx,
    input logic [15:0] i_cfg_data
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not empty after reset");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall raised without a blocked result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_color_index))
        else $error("stalled result beat changed");
endmodule

bind tunnel_texture_pixel_generator ttpg_checker u_ttpg_checker (.*);

// ===== tb/ttpg_checker.sv =====
// Scoreboard for the tunnel pixel generator: predicts each color index from accepted pixel beats.
// Mirrors the configuration port; depends on ttpg_pkg for the reset values and register index names.
`timescale 1ns / 1ps

module ttpg_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [8:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    input  logic [15:0] i_frame_number,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [7:0]  o_color_index,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    localparam longint PI_RAD     = 64'd3373259426;
    localparam longint HALF_PI_RAD = 64'd1686629713;
    localparam longint ARC_STEP [16] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
        8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768
    };

    logic [15:0] scale;
    logic [9:0]  xdiv;
    logic [9:0]  ydiv;
    logic [8:0]  period;
    logic [8:0]  cx;
    logic [7:0]  cy;
    logic [7:0]  color_fifo [$];
    int          errors = 0;

    assign o_errors  = errors;
    assign o_pending = color_fifo.size();

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint first_quadrant(input longint ax, input longint ay);
        longint x;
        longint y;
        longint z;
        longint nx;
        x = ax <<< 20;
        y = ay <<< 20;
        z = 0;
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ARC_STEP[i];
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ARC_STEP[i];
            end
            x = nx;
        end
        if (z < 0) z = 0;
        if (z > HALF_PI_RAD) z = HALF_PI_RAD;
        return z;
    endfunction

    function automatic logic [7:0] predict_color(input logic [8:0] px, input logic [7:0] py,
                                                 input logic [15:0] fr);
        longint dx;
        longint dy;
        longint a;
        longint unsigned d2;
        longint unsigned s;
        longint unsigned mag;
        longint unsigned t;
        logic [7:0] depth;
        logic [7:0] ang;
        logic [7:0] u;
        logic [7:0] v;
        longint unsigned xd;
        longint unsigned yd;
        longint unsigned per;
        dx = longint'(px) - longint'(cx);
        dy = longint'(py) - longint'(cy);
        d2 = dx * dx + dy * dy;
        depth = 0;
        if (d2 != 0) begin
            s = scale;
            depth = 8'(int_sqrt((s * s) / d2));
        end
        if (dy == 0) begin
            a = (dx < 0) ? PI_RAD : 0;
        end else if (dx == 0) begin
            a = (dy < 0) ? -HALF_PI_RAD : HALF_PI_RAD;
        end else begin
            a = first_quadrant(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
            if (dx < 0) a = PI_RAD - a;
            if (dy < 0) a = -a;
        end
        mag = (a < 0) ? -a : a;
        t = (mag * 160000) / (64'd3927 << 30);
        ang = (a < 0) ? 8'(256 - (t & 255)) : 8'(t);
        xd  = (xdiv == 0) ? 1 : xdiv;
        yd  = (ydiv == 0) ? 1 : ydiv;
        per = (period == 0) ? 256 : period;
        u = 8'(depth + (256 * longint'(fr)) / xd);
        v = 8'(ang + (256 * longint'(fr)) / yd);
        return 8'((u ^ v) % per);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scale  <= ttpg_pkg::RST_SCALE;
            xdiv   <= ttpg_pkg::RST_XDIV;
            ydiv   <= ttpg_pkg::RST_YDIV;
            period <= ttpg_pkg::RST_PERIOD;
            cx     <= ttpg_pkg::RST_CX;
            cy     <= ttpg_pkg::RST_CY;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ttpg_pkg::CFG_SCALE:  scale  <= i_cfg_data;
                    ttpg_pkg::CFG_XDIV:   xdiv   <= i_cfg_data[9:0];
                    ttpg_pkg::CFG_YDIV:   ydiv   <= i_cfg_data[9:0];
                    ttpg_pkg::CFG_PERIOD: period <= i_cfg_data[8:0];
                    ttpg_pkg::CFG_CX:     cx     <= i_cfg_data[8:0];
                    ttpg_pkg::CFG_CY:     cy     <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                color_fifo.push_back(predict_color(i_pixel_x, i_pixel_y, i_frame_number));
            if (o_valid && !i_stall) begin
                if (color_fifo.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected color beat %0d at %0t", o_color_index, $realtime);
                end else if (color_fifo[0] !== o_color_index) begin
                    errors++;
                    if (errors <= 10)
                        $display("Color mismatch: expected %0d, got %0d at %0t",
                                 color_fifo[0], o_color_index, $realtime);
                    void'(color_fifo.pop_front());
                end else begin
                    void'(color_fifo.pop_front());
                end
            end
        end
    end

endmodule

// ===== tb/tunnel_texture_pixel_generator_test.sv =====
// Top of the tunnel pixel generator testbench: clock, reset, stimulus and the verdict.
// Depends on ttpg_pkg, the block itself and ttpg_scoreboard.
`timescale 1ns / 1ps

module tunnel_texture_pixel_generator_test;
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [8:0]  i_pixel_x = 0;
    logic [7:0]  i_pixel_y = 0;
    logic [15:0] i_frame_number = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [7:0]  o_color_index;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = 0;
    logic [15:0] i_cfg_data = 0;
    int          errors;
    int          pending;
    bit          calm = 0;
    bit          hold_go = 0;
    bit          hold_ack = 0;
    int          hold_left = 0;
    int          cycles = 0;

    always #2 i_clk = ~i_clk;

    tunnel_texture_pixel_generator DUT (.*);

    ttpg_scoreboard scoreboard (.*, .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL tunnel_texture_pixel_generator");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_go != hold_ack) begin
            hold_ack = hold_go;
            hold_left = 400;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 11);
        end
    end

    task automatic push_pixel(input logic [8:0] x, input logic [7:0] y, input logic [15:0] f);
        bit taken;
        if (!calm && $urandom_range(99) < 11) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        i_frame_number <= f;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_pixels(input int count);
        logic [8:0] x;
        logic [7:0] y;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0) begin
                x = 9'($urandom);
                y = 8'($urandom);
            end else begin
                x = 9'($urandom_range(319));
                y = 8'($urandom_range(239));
            end
            push_pixel(x, y, 16'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_pixel(9'd160, 8'd120, 16'd0);
        push_pixel(9'd160, 8'd120, 16'hFFFF);
        push_pixel(9'd200, 8'd120, 16'd7);
        push_pixel(9'd100, 8'd120, 16'd8);
        push_pixel(9'd160, 8'd10, 16'd9);
        push_pixel(9'd160, 8'd230, 16'd10);
        push_pixel(9'd0, 8'd0, 16'd0);
        push_pixel(9'd319, 8'd239, 16'hFFFF);
        push_pixel(9'd0, 8'd239, 16'd300);
        push_pixel(9'd319, 8'd0, 16'd301);
        push_pixel(9'd511, 8'd255, 16'h5555);
        push_pixel(9'd161, 8'd121, 16'hAAAA);
        push_pixel(9'd159, 8'd119, 16'd1);
        drain();

        write_reg(ttpg_pkg::CFG_SCALE, 16'hFFFF);
        write_reg(ttpg_pkg::CFG_XDIV, 16'd0);
        write_reg(ttpg_pkg::CFG_YDIV, 16'd0);
        write_reg(ttpg_pkg::CFG_PERIOD, 16'd0);
        write_reg(ttpg_pkg::CFG_CX, 16'd0);
        write_reg(ttpg_pkg::CFG_CY, 16'd0);
        write_reg(CFG_SPARE_LO, 16'h1234);
        push_pixel(9'd0, 8'd0, 16'd5);
        push_pixel(9'd1, 8'd0, 16'hFFFF);
        push_pixel(9'd0, 8'd1, 16'd3);
        push_pixel(9'd511, 8'd255, 16'hFFFF);
        random_pixels(120);
        drain();

        write_reg(ttpg_pkg::CFG_SCALE, 16'd1);
        write_reg(ttpg_pkg::CFG_XDIV, 16'd1023);
        write_reg(ttpg_pkg::CFG_YDIV, 16'd1);
        write_reg(ttpg_pkg::CFG_PERIOD, 16'd1);
        write_reg(ttpg_pkg::CFG_CX, 16'd319);
        write_reg(ttpg_pkg::CFG_CY, 16'd239);
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        calm = 1;
        random_pixels(120);
        calm = 0;
        drain();

        write_reg(ttpg_pkg::CFG_SCALE, 16'h8000);
        write_reg(ttpg_pkg::CFG_XDIV, 16'd1);
        write_reg(ttpg_pkg::CFG_YDIV, 16'd1023);
        write_reg(ttpg_pkg::CFG_PERIOD, 16'd256);
        write_reg(ttpg_pkg::CFG_CX, 16'd511);
        write_reg(ttpg_pkg::CFG_CY, 16'd255);
        hold_go = !hold_go;
        random_pixels(130);
        drain();

        write_reg(ttpg_pkg::CFG_SCALE, 16'($urandom_range(1, 65535)));
        write_reg(ttpg_pkg::CFG_XDIV, 16'($urandom_range(1, 1023)));
        write_reg(ttpg_pkg::CFG_YDIV, 16'($urandom_range(1, 1023)));
        write_reg(ttpg_pkg::CFG_PERIOD, 16'd511);
        write_reg(ttpg_pkg::CFG_CX, 16'd160);
        write_reg(ttpg_pkg::CFG_CY, 16'd120);
        random_pixels(120);
        drain();

        for (int p = 0; p < 2; p++) begin
            write_reg(ttpg_pkg::CFG_SCALE, 16'($urandom));
            write_reg(ttpg_pkg::CFG_XDIV, 16'($urandom));
            write_reg(ttpg_pkg::CFG_YDIV, 16'($urandom));
            write_reg(ttpg_pkg::CFG_PERIOD, 16'($urandom_range(1, 256)));
            write_reg(ttpg_pkg::CFG_CX, 16'($urandom_range(319)));
            write_reg(ttpg_pkg::CFG_CY, 16'($urandom_range(239)));
            random_pixels(125);
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("PASS tunnel_texture_pixel_generator");
        end else begin
            $display("FAIL tunnel_texture_pixel_generator");
        end
        $finish;
    end

endmodule
